FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

FILE: sv/med_pkg.sv
// ----------------------------------------------------------------------------
// med_pkg
// shared widths, constants and control types of the distance block
// ----------------------------------------------------------------------------
package med_pkg;

  localparam int unsigned ElemW      = 16;
  localparam int unsigned MagW       = 16;
  localparam int unsigned SqW        = 32;
  localparam int unsigned SumW       = 40;
  localparam int unsigned RootW      = 41;
  localparam int unsigned DistW      = 21;
  localparam int unsigned RootIters  = 20;
  localparam int unsigned IterCntW   = 5;
  localparam int unsigned InTdataW   = 32;
  localparam int unsigned OutTdataW  = 48;

  localparam logic [DistW-1:0] MinStartRst = 21'd1638400;
  localparam logic [SumW-1:0]  SumMax      = {SumW{1'b1}};
  localparam logic [DistW-1:0] DistMax     = {DistW{1'b1}};
  localparam logic [RootW-1:0] BitInit     = RootW'(64'd1 << 38);

  typedef struct packed {
    logic sq_load;     // capture squared difference of an accepted word
    logic sqrt_start;  // move final sum into root unit, clear accumulator
    logic sqrt_step;   // one root iteration
    logic out_load;    // fill output register, update running minimum
  } med_cmd_t;

  typedef struct packed {
    logic out_free;    // output register empty or drained this cycle
  } med_sts_t;

endpackage

FILE: sv/med_ctrl.sv
// ----------------------------------------------------------------------------
// med_ctrl
// sequencer: accumulate, flush, square root iterations, result hand-off
// ----------------------------------------------------------------------------
module med_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tlast_i,
  output logic              s_tready_o,
  output med_pkg::med_cmd_t cmd_o,
  input  med_pkg::med_sts_t sts_i
);

  localparam logic [1:0] StAcc   = 2'd0;
  localparam logic [1:0] StFlush = 2'd1;
  localparam logic [1:0] StSqrt  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [med_pkg::IterCntW-1:0] cnt_q, cnt_d;
  logic                         accept;

  assign s_tready_o = (state_q == StAcc);
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.sq_load = accept;
    case (state_q)
      StAcc: begin
        if (accept && s_tlast_i) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        cmd_o.sqrt_start = 1'b1;
        cnt_d            = '0;
        state_d          = StSqrt;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == med_pkg::IterCntW'(med_pkg::RootIters - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StAcc;
        end
      end
      default: begin
        state_d = StAcc;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAcc;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: sv/med_dp.sv
// ----------------------------------------------------------------------------
// med_dp
// datapath: squared difference, saturating sum, bitwise root, running minimum
// ----------------------------------------------------------------------------
module med_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  med_pkg::med_cmd_t                cmd_i,
  output med_pkg::med_sts_t                sts_o,
  input  logic [med_pkg::ElemW-1:0]        stored_elem_i,
  input  logic [med_pkg::ElemW-1:0]        query_elem_i,
  input  logic                             last_desc_i,
  input  logic                             cfg_we_i,
  input  logic [med_pkg::DistW-1:0]        cfg_wdata_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [med_pkg::DistW-1:0]        distance_o,
  output logic [med_pkg::DistW-1:0]        best_distance_o,
  output logic                             person_done_o
);

  localparam int unsigned DiffW = med_pkg::ElemW + 1;

  logic signed [DiffW-1:0]         diff;
  logic [DiffW-1:0]                diff_abs;
  logic [med_pkg::MagW-1:0]        mag;
  logic [med_pkg::SqW-1:0]         sq_q;
  logic                            sq_vld_q;
  logic [med_pkg::SumW:0]          sum_wide;
  logic [med_pkg::SumW-1:0]        sum_q, sum_d;
  logic [med_pkg::SumW-1:0]        rem_q;
  logic [med_pkg::RootW-1:0]       root_q, bit_q;
  logic [med_pkg::RootW:0]         trial;
  logic                            take;
  logic [med_pkg::DistW-1:0]       root_dist, best;
  logic                            last_desc_q;
  logic [med_pkg::DistW-1:0]       min_start_q, run_min_q;
  logic                            person_open_q;
  logic                            out_vld_q;

  // |stored - query| fits 16 bits unsigned
  assign diff     = $signed({stored_elem_i[med_pkg::ElemW-1], stored_elem_i})
                  - $signed({query_elem_i[med_pkg::ElemW-1], query_elem_i});
  assign diff_abs = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign mag      = diff_abs[med_pkg::MagW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_load) begin
      sq_q <= mag * mag;
    end
    if (cmd_i.sq_load) begin
      last_desc_q <= last_desc_i;
    end
  end

  // saturating accumulate of the registered square
  assign sum_wide = {1'b0, sum_q}
                  + (med_pkg::SumW + 1)'(sq_vld_q ? sq_q : '0);
  assign sum_d    = sum_wide[med_pkg::SumW] ? med_pkg::SumMax
                                            : sum_wide[med_pkg::SumW-1:0];

  // one root bit per cycle
  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign take  = ({2'b00, rem_q} >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rem_q  <= sum_d;
      root_q <= '0;
      bit_q  <= med_pkg::BitInit;
    end else if (cmd_i.sqrt_step) begin
      if (take) begin
        rem_q  <= rem_q - trial[med_pkg::SumW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_dist = (|root_q[med_pkg::RootW-1:med_pkg::DistW]) ? med_pkg::DistMax
                                                                : root_q[med_pkg::DistW-1:0];
  assign best = (root_dist < run_min_q) ? root_dist : run_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q      <= 1'b0;
      sum_q         <= '0;
      min_start_q   <= med_pkg::MinStartRst;
      run_min_q     <= med_pkg::MinStartRst;
      person_open_q <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      sq_vld_q <= cmd_i.sq_load;
      sum_q    <= cmd_i.sqrt_start ? '0 : sum_d;
      if (cfg_we_i) begin
        min_start_q <= cfg_wdata_i;
        if (!person_open_q) begin
          run_min_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.out_load) begin
        run_min_q     <= last_desc_q ? min_start_q : best;
        person_open_q <= !last_desc_q;
        out_vld_q     <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      distance_o      <= root_dist;
      best_distance_o <= best;
      person_done_o   <= last_desc_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

endmodule

FILE: sv/min_euclidean_distance.sv
// ----------------------------------------------------------------------------
// min_euclidean_distance - nearest-neighbour euclidean distance
// last word path: square register, flush, root iterations, output register
// throughput: one word per cycle inside a descriptor, then tready stays low
//   for flush and 20-step root, longer while the last result is not taken
// reset: async active low, clears the sum and loads the minimum with 100.0
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_euclidean_distance (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] stored_elem, [31:16] query_elem
  input  logic        s_axis_tlast,   // last_elem
  input  logic        s_axis_tuser,   // last_descriptor
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [20:0] distance, [41:21] best_distance,
                                      // [47:42] zero
  output logic        m_axis_tlast,   // person_done
  // starting minimum, q.14
  input  logic        cfg_we_i,
  input  logic [20:0] cfg_wdata_i
);

  med_pkg::med_cmd_t cmd;
  med_pkg::med_sts_t sts;

  logic [med_pkg::DistW-1:0] distance;
  logic [med_pkg::DistW-1:0] best_distance;

  // sequencer: holds tready low from the last word until the root is handed off
  med_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath: squares are registered ahead of the 40-bit sum, the
  // root unit shares nothing with the accumulator so the next descriptor can
  // stream in while a finished result still waits in the output register
  med_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .stored_elem_i   (s_axis_tdata[15:0]),
    .query_elem_i    (s_axis_tdata[31:16]),
    .last_desc_i     (s_axis_tuser),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .distance_o      (distance),
    .best_distance_o (best_distance),
    .person_done_o   (m_axis_tlast)
  );

  // pack result word, distance in the low bits
  assign m_axis_tdata = {6'b0, best_distance, distance};

  // a descriptor's last word stops intake on the next cycle
  `ASSERT_PROP(a_last_stalls, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)

  // root unit is only started by a last word accepted in the previous cycle
  `ASSERT_PROP(a_start_after_last, clk_i, rst_ni,
    cmd.sqrt_start |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))

  // result is never loaded over a word that has not been taken
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.out_load && !sts.out_free)

  // running minimum never exceeds the distance it includes
  `ASSERT_PROP(a_best_le_dist, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[41:21] <= m_axis_tdata[20:0]))

endmodule

FILE: tb/tb_min_euclidean_distance.sv
// ----------------------------------------------------------------------------
// tb_min_euclidean_distance - self-checking bench of the distance block
// streams element pairs into min_euclidean_distance and compares each result
// word with a cycle-free model of the squared-difference sum, the floor
// square root and the per-person running minimum; the starting minimum is
// rewritten between phases while the block is idle
// ----------------------------------------------------------------------------
module tb_min_euclidean_distance;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned TimeoutNs   = 5_000_000;

  typedef struct packed {
    logic [med_pkg::DistW-1:0] distance;
    logic [med_pkg::DistW-1:0] best_distance;
    logic                      person_done;
  } dist_result_t;

  // dut ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [20:0] cfg_wdata_i   = '0;

  // model state of the block
  logic [med_pkg::SumW-1:0]  acc_sum     = '0;
  logic [med_pkg::DistW-1:0] min_start_q = med_pkg::MinStartRst;
  logic [med_pkg::DistW-1:0] best_min    = med_pkg::MinStartRst;
  logic                      person_open = 1'b0;

  dist_result_t pending_dist_q[$];
  int unsigned  err_cnt      = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  dst_idle_pct = 0;

  min_euclidean_distance u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case a handshake hangs
  initial begin
    #(TimeoutNs);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // floor square root, one result bit per pass from the top down
  function automatic logic [19:0] floor_root(input logic [med_pkg::SumW-1:0] v);
    logic [19:0] r;
    logic [19:0] c;
    r = '0;
    for (int b = 19; b >= 0; b--) begin
      c = r | (20'd1 << b);
      if (40'(c) * 40'(c) <= v) r = c;
    end
    return r;
  endfunction

  // fold one accepted word into the model, queue a result on descriptor end
  task automatic track_word(input logic [15:0] stored, input logic [15:0] query,
                            input logic elem_last, input logic desc_last);
    logic signed [16:0]        diff;
    logic [15:0]               mag;
    logic [med_pkg::SumW:0]    sum_next;
    logic [med_pkg::DistW-1:0] desc_dist;
    dist_result_t              res;
    diff     = 17'($signed(stored)) - 17'($signed(query));
    mag      = diff[16] ? 16'(-diff) : 16'(diff);
    sum_next = {1'b0, acc_sum} + (med_pkg::SumW + 1)'(32'(mag) * 32'(mag));
    acc_sum  = (sum_next > {1'b0, med_pkg::SumMax}) ? med_pkg::SumMax
                                                     : sum_next[med_pkg::SumW-1:0];
    if (elem_last) begin
      desc_dist = med_pkg::DistW'(floor_root(acc_sum));
      if (desc_dist < best_min) best_min = desc_dist;
      person_open = 1'b1;
      res.distance      = desc_dist;
      res.best_distance = best_min;
      res.person_done   = desc_last;
      pending_dist_q.push_back(res);
      acc_sum = '0;
      // person closed: next one starts from the configured minimum
      if (desc_last) begin
        best_min    = min_start_q;
        person_open = 1'b0;
      end
    end
  endtask

  task automatic check_result();
    dist_result_t exp_res;
    if (pending_dist_q.size() == 0) begin
      $error("result word with nothing pending: tdata %h tlast %b", m_axis_tdata,
             m_axis_tlast);
      err_cnt++;
    end else begin
      exp_res = pending_dist_q.pop_front();
      if (m_axis_tdata[20:0] !== exp_res.distance) begin
        $error("distance mismatch: expected %0d, actual %0d", exp_res.distance,
               m_axis_tdata[20:0]);
        err_cnt++;
      end
      if (m_axis_tdata[41:21] !== exp_res.best_distance) begin
        $error("best_distance mismatch: expected %0d, actual %0d", exp_res.best_distance,
               m_axis_tdata[41:21]);
        err_cnt++;
      end
      if (m_axis_tdata[47:42] !== 6'd0) begin
        $error("tdata pad mismatch: expected %0d, actual %0d", 6'd0, m_axis_tdata[47:42]);
        err_cnt++;
      end
      if (m_axis_tlast !== exp_res.person_done) begin
        $error("person_done mismatch: expected %0d, actual %0d", exp_res.person_done,
               m_axis_tlast);
        err_cnt++;
      end
    end
  endtask

  // everything is sampled at the rising edge, before the dut's own updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        min_start_q = cfg_wdata_i;
        // only an idle person picks up the new start value at once
        if (!person_open) best_min = min_start_q;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_word(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
  end

  // one input word; valid stays high on return so words can go back to back
  task automatic send_word(input logic [15:0] stored, input logic [15:0] query,
                           input logic elem_last, input logic desc_last);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {query, stored};
    s_axis_tlast  <= elem_last;
    s_axis_tuser  <= desc_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop sending and let every pending result and the root unit drain
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_dist_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic load_min_start(input logic [med_pkg::DistW-1:0] value);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 21'($urandom());
  endtask

  // single-word descriptor whose distance equals the given value, if below 32768
  task automatic send_dist(input logic [15:0] d, input logic desc_last);
    send_word(d, 16'd0, 1'b1, desc_last);
  endtask

  // element pair: full random, near-equal, equal or an extreme value
  task automatic gen_pair(output logic [15:0] stored, output logic [15:0] query);
    logic [15:0] corner[4];
    int unsigned mode;
    corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    mode   = $urandom_range(9);
    stored = 16'($urandom());
    if (mode <= 3) query = 16'($urandom());
    else if (mode <= 6) query = stored + 16'($signed($urandom_range(128)) - 64);
    else if (mode == 7) query = stored;
    else if (mode == 8) begin
      stored = corner[$urandom_range(3)];
      query  = corner[$urandom_range(3)];
    end else query = corner[$urandom_range(3)];
  endtask

  // noisy descriptors also raise last_descriptor on inner words
  task automatic send_descriptor(input int len, input logic desc_last, input bit noisy);
    logic [15:0] s;
    logic [15:0] q;
    for (int i = 0; i < len; i++) begin
      gen_pair(s, q);
      if (i == len - 1) send_word(s, q, 1'b1, desc_last);
      else send_word(s, q, 1'b0, noisy && ($urandom_range(1) == 0));
    end
  endtask

  task automatic test_elem_extremes();
    send_word(16'h7FFF, 16'h8000, 1'b1, 1'b0);
    send_word(16'h8000, 16'h7FFF, 1'b1, 1'b0);
    send_word(16'h0000, 16'h0000, 1'b1, 1'b0);
    send_word(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_word(16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    send_word(16'hFFFF, 16'h0001, 1'b1, 1'b0);
    send_word(16'h0001, 16'hFFFF, 1'b0, 1'b0);
    send_word(16'h5555, 16'hAAAA, 1'b0, 1'b0);
    send_word(16'hAAAA, 16'h5555, 1'b1, 1'b1);
  endtask

  // last_descriptor on words that do not end a descriptor has no effect
  task automatic test_ignored_flag();
    send_word(16'h0100, 16'h0000, 1'b0, 1'b1);
    send_word(16'h0000, 16'h0100, 1'b0, 1'b1);
    send_word(16'h0010, 16'h0020, 1'b1, 1'b0);
    send_word(16'h0003, 16'h0000, 1'b1, 1'b1);
  endtask

  // minimum kept across descriptors, equal distance does not replace it
  task automatic test_min_tracking();
    load_min_start(21'd1000);
    send_dist(16'd2000, 1'b0);
    send_dist(16'd700, 1'b0);
    send_dist(16'd900, 1'b0);
    send_dist(16'd700, 1'b0);
    send_dist(16'd50, 1'b1);
  endtask

  // written with no person open: takes effect on the next descriptor
  task automatic test_config_immediate();
    load_min_start(21'd0);
    send_dist(16'd5, 1'b1);
    load_min_start(med_pkg::DistMax);
    send_dist(16'd12345, 1'b1);
  endtask

  // written mid-person: the open person keeps its minimum
  task automatic test_config_mid_person();
    load_min_start(21'd3000);
    send_dist(16'd2500, 1'b0);
    load_min_start(21'd10);
    send_dist(16'd2600, 1'b1);
    send_dist(16'd20, 1'b1);
  endtask

  // far beyond the nominal length: the sum clips at its maximum
  task automatic test_long_descriptor();
    load_min_start(med_pkg::MinStartRst);
    for (int i = 0; i < 299; i++) send_word(16'h7FFF, 16'h8000, 1'b0, 1'b0);
    send_word(16'h7FFF, 16'h8000, 1'b1, 1'b1);
  endtask

  // whole persons of 1..4 descriptors, mostly short, a few at full length
  task automatic run_random_phase(input int n_words);
    int sent;
    int ndesc;
    int len;
    bit noisy;
    sent = 0;
    while (sent < n_words) begin
      ndesc = $urandom_range(1, 4);
      noisy = ($urandom_range(9) == 0);
      for (int d = 0; d < ndesc; d++) begin
        if ($urandom_range(39) == 0) len = $urandom_range(64, 128);
        else len = $urandom_range(1, 8);
        send_descriptor(len, d == ndesc - 1, noisy);
        sent += len;
      end
    end
  endtask

  initial begin
    src_idle_pct = 18;
    dst_idle_pct = 55;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_elem_extremes();
    test_ignored_flag();
    test_min_tracking();
    test_config_immediate();
    test_config_mid_person();
    test_long_descriptor();

    // sender lightly idle, receiver often stalled
    load_min_start(21'($urandom_range(200000)));
    run_random_phase(250);
    // roles swapped, start from the largest minimum
    src_idle_pct = 55;
    dst_idle_pct = 18;
    load_min_start(med_pkg::DistMax);
    run_random_phase(250);
    // full rate on both sides
    src_idle_pct = 0;
    dst_idle_pct = 0;
    load_min_start(21'($urandom()));
    run_random_phase(250);

    wait_drain();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/med_pkg.sv
sv/med_ctrl.sv
sv/med_dp.sv
sv/min_euclidean_distance.sv
tb/tb_min_euclidean_distance.sv
